// File: rtl/ptt_pkg.sv
// Package for the pair result tally table: item structs, opcodes, outcome
// and status codes, and the control group driven into the cell row.
// No dependencies.
package ptt_pkg;

    localparam int ID_W    = 10;
    localparam int CNT_W   = 20;
    localparam int SCORE_W = 21;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2
    } t_opcode;

    localparam logic [1:0] OUTC_FIRST_WIN  = 2'd0;
    localparam logic [1:0] OUTC_DRAW       = 2'd1;
    localparam logic [1:0] OUTC_SECOND_WIN = 2'd2;
    localparam logic [1:0] OUTC_DISCARD    = 2'd3;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_MERGED   = 3'd1,
        ST_SKIPPED  = 3'd2,
        ST_FULL     = 3'd3,
        ST_ENTRY    = 3'd4,
        ST_NONE     = 3'd5,
        ST_CLEARED  = 3'd6
    } t_status;

    typedef struct packed {
        logic [1:0]      opcode;
        logic [ID_W-1:0] first_id;
        logic [ID_W-1:0] second_id;
        logic [1:0]      outcome;
        logic            first_flagged;
        logic            second_flagged;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         status;
        logic [ID_W-1:0]    entry_first_id;
        logic [ID_W-1:0]    entry_second_id;
        logic [CNT_W-1:0]   played_count;
        logic [CNT_W-1:0]   win_count;
        logic [CNT_W-1:0]   draw_count;
        logic [CNT_W-1:0]   loss_count;
        logic [SCORE_W-1:0] score_halves;
        logic               last_entry;
    } t_out_item;

    // Broadcast to every cell for the item being applied.
    typedef struct packed {
        logic       insert;
        logic       merge;
        logic [1:0] outcome;
    } t_cell_ctrl;

endpackage

// File: rtl/ptt_cell.sv
// One cell of the sorted tally row: holds one entry, compares it with the
// incoming key, and takes its left neighbor's entry when an insert shifts.
// Depends on ptt_pkg.
module ptt_cell #(
    parameter int ID_BITS    = 10,
    parameter int COUNT_BITS = 20,
    parameter int TOT_W      = 7,
    parameter int CELL_INDEX = 0
) (
    input  logic                                  i_clk,
    input  ptt_pkg::t_cell_ctrl                   i_ctrl,
    input  logic [TOT_W-1:0]                      i_total,
    input  logic [2*ID_BITS-1:0]                  i_key,
    input  logic                                  i_prev_lt,
    input  logic [2*ID_BITS+5*COUNT_BITS:0]       i_prev_entry,
    output logic                                  o_lt,
    output logic                                  o_eq,
    output logic [2*ID_BITS+5*COUNT_BITS:0]       o_entry
);

    localparam int KEY_W   = 2 * ID_BITS;
    localparam int SC_W    = COUNT_BITS + 1;
    localparam int CNTS_W  = 4 * COUNT_BITS + SC_W;
    localparam int ENTRY_W = KEY_W + CNTS_W;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
    localparam logic [SC_W-1:0]       SC_MAX  = '1;

    logic [ENTRY_W-1:0] r_entry;
    logic [ENTRY_W-1:0] n_entry;
    logic [KEY_W-1:0]   w_key;
    logic               w_valid;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
        return (c == CNT_MAX) ? c : c + COUNT_BITS'(1);
    endfunction

    // Counts are laid out played, wins, draws, losses, score from the top.
    function automatic logic [CNTS_W-1:0] tally(input logic [CNTS_W-1:0] c,
                                                 input logic [1:0] outcome);
        logic [COUNT_BITS-1:0] played;
        logic [COUNT_BITS-1:0] wins;
        logic [COUNT_BITS-1:0] draws;
        logic [COUNT_BITS-1:0] losses;
        logic [SC_W-1:0]       score;
        played = c[CNTS_W-1 -: COUNT_BITS];
        wins   = c[CNTS_W-1-COUNT_BITS -: COUNT_BITS];
        draws  = c[CNTS_W-1-2*COUNT_BITS -: COUNT_BITS];
        losses = c[CNTS_W-1-3*COUNT_BITS -: COUNT_BITS];
        score  = c[SC_W-1:0];
        played = sat_inc(played);
        case (outcome)
            ptt_pkg::OUTC_FIRST_WIN: begin
                wins  = sat_inc(wins);
                score = (score >= SC_MAX - SC_W'(1)) ? SC_MAX : score + SC_W'(2);
            end
            ptt_pkg::OUTC_DRAW: begin
                draws = sat_inc(draws);
                score = (score == SC_MAX) ? score : score + SC_W'(1);
            end
            default: begin
                losses = sat_inc(losses);
            end
        endcase
        return {played, wins, draws, losses, score};
    endfunction

    assign w_key   = r_entry[ENTRY_W-1 -: KEY_W];
    assign w_valid = i_total > TOT_W'(CELL_INDEX);
    assign o_lt    = w_valid && (w_key < i_key);
    assign o_eq    = w_valid && (w_key == i_key);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.insert) begin
            // Cells below the insert point hold; the one at it takes the new
            // key, and every cell above takes its left neighbor's entry.
            if (!o_lt) begin
                if (i_prev_lt) begin
                    n_entry = {i_key, tally('0, i_ctrl.outcome)};
                end else begin
                    n_entry = i_prev_entry;
                end
            end
        end else if (i_ctrl.merge && o_eq) begin
            n_entry = {w_key, tally(r_entry[CNTS_W-1:0], i_ctrl.outcome)};
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

// File: rtl/pair_result_tally_table.sv
// Sorted (first id, second id) tally table built as a row of cells, one entry
// per cell. For every item all cells compare the key at once, and an insert
// shifts the upper part of the row one cell to the right in that same cycle,
// so busy never rises and a new item may follow every cycle. Each item gives
// one result in the cycle after it is accepted, shown for a single cycle on
// o_result_valid; the receiver cannot stall it. Reads walk the table in
// order through a selector on the cell outputs.
// Depends on ptt_pkg and ptt_cell.
module pair_result_tally_table #(
    parameter int TABLE_DEPTH = 64,
    parameter int ID_BITS     = 10,
    parameter int COUNT_BITS  = 20
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  ptt_pkg::t_in_item  i_item,
    output logic               o_result_valid,
    output ptt_pkg::t_out_item o_result,
    input  logic               i_cfg_wr_en,
    input  logic               i_cfg_wr_data
);

    localparam int KEY_W   = 2 * ID_BITS;
    localparam int SC_W    = COUNT_BITS + 1;
    localparam int ENTRY_W = KEY_W + 4 * COUNT_BITS + SC_W;
    localparam int TOT_W   = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W   = $clog2(TABLE_DEPTH);

    logic                 r_skip_mode;
    logic [TOT_W-1:0]     r_total;
    logic [TOT_W-1:0]     n_total;
    logic [TOT_W-1:0]     r_rdpos;
    logic [TOT_W-1:0]     n_rdpos;
    logic                 r_out_valid;
    ptt_pkg::t_out_item   r_result;
    ptt_pkg::t_out_item   n_result;
    ptt_pkg::t_cell_ctrl  w_ctrl;
    logic                 w_accept;
    logic [KEY_W-1:0]     w_key;
    logic [TABLE_DEPTH-1:0] w_lt;
    logic [TABLE_DEPTH-1:0] w_eq;
    logic [ENTRY_W-1:0]   w_entry [TABLE_DEPTH];
    logic [ENTRY_W-1:0]   w_rd_entry;
    logic                 w_found;
    logic                 w_full;
    logic                 w_skip;

    // The whole update completes in the cycle of acceptance.
    assign busy     = 1'b0;
    assign w_accept = start && !busy;
    assign w_key    = {ID_BITS'(i_item.first_id), ID_BITS'(i_item.second_id)};
    assign w_found  = |w_eq;
    assign w_full   = (r_total == TOT_W'(TABLE_DEPTH));
    assign w_skip   = (i_item.outcome == ptt_pkg::OUTC_DISCARD)
                   || (r_skip_mode && (i_item.first_flagged || i_item.second_flagged));
    assign w_rd_entry = w_entry[r_rdpos[IDX_W-1:0]];

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_head
            ptt_cell #(
                .ID_BITS(ID_BITS), .COUNT_BITS(COUNT_BITS),
                .TOT_W(TOT_W), .CELL_INDEX(g)
            ) u_cell (
                .i_clk       (i_clk),
                .i_ctrl      (w_ctrl),
                .i_total     (r_total),
                .i_key       (w_key),
                .i_prev_lt   (1'b1),
                .i_prev_entry('0),
                .o_lt        (w_lt[g]),
                .o_eq        (w_eq[g]),
                .o_entry     (w_entry[g])
            );
        end else begin : g_body
            ptt_cell #(
                .ID_BITS(ID_BITS), .COUNT_BITS(COUNT_BITS),
                .TOT_W(TOT_W), .CELL_INDEX(g)
            ) u_cell (
                .i_clk       (i_clk),
                .i_ctrl      (w_ctrl),
                .i_total     (r_total),
                .i_key       (w_key),
                .i_prev_lt   (w_lt[g-1]),
                .i_prev_entry(w_entry[g-1]),
                .o_lt        (w_lt[g]),
                .o_eq        (w_eq[g]),
                .o_entry     (w_entry[g])
            );
        end
    end

    always_comb begin
        n_total        = r_total;
        n_rdpos        = r_rdpos;
        n_result       = '0;
        n_result.status = ptt_pkg::ST_NONE;
        w_ctrl         = '0;
        w_ctrl.outcome = i_item.outcome;
        if (w_accept) begin
            case (i_item.opcode)
                ptt_pkg::OP_ADD: begin
                    if (w_skip) begin
                        n_result.status = ptt_pkg::ST_SKIPPED;
                    end else if (w_found) begin
                        w_ctrl.merge    = 1'b1;
                        n_result.status = ptt_pkg::ST_MERGED;
                    end else if (w_full) begin
                        n_result.status = ptt_pkg::ST_FULL;
                    end else begin
                        w_ctrl.insert   = 1'b1;
                        n_total         = r_total + TOT_W'(1);
                        n_result.status = ptt_pkg::ST_INSERTED;
                    end
                end
                ptt_pkg::OP_READ: begin
                    if (r_rdpos < r_total) begin
                        n_result.status          = ptt_pkg::ST_ENTRY;
                        n_result.entry_first_id  =
                            ptt_pkg::ID_W'(w_rd_entry[ENTRY_W-1 -: ID_BITS]);
                        n_result.entry_second_id =
                            ptt_pkg::ID_W'(w_rd_entry[ENTRY_W-1-ID_BITS -: ID_BITS]);
                        n_result.played_count    =
                            ptt_pkg::CNT_W'(w_rd_entry[ENTRY_W-1-KEY_W -: COUNT_BITS]);
                        n_result.win_count       = ptt_pkg::CNT_W'(
                            w_rd_entry[ENTRY_W-1-KEY_W-COUNT_BITS -: COUNT_BITS]);
                        n_result.draw_count      = ptt_pkg::CNT_W'(
                            w_rd_entry[ENTRY_W-1-KEY_W-2*COUNT_BITS -: COUNT_BITS]);
                        n_result.loss_count      = ptt_pkg::CNT_W'(
                            w_rd_entry[ENTRY_W-1-KEY_W-3*COUNT_BITS -: COUNT_BITS]);
                        n_result.score_halves    = ptt_pkg::SCORE_W'(w_rd_entry[SC_W-1:0]);
                        n_result.last_entry      = (r_rdpos + TOT_W'(1) == r_total);
                        n_rdpos                  = r_rdpos + TOT_W'(1);
                    end
                end
                ptt_pkg::OP_CLEAR: begin
                    n_total         = '0;
                    n_rdpos         = '0;
                    n_result.status = ptt_pkg::ST_CLEARED;
                end
                default: begin
                    n_result.status = ptt_pkg::ST_NONE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip_mode <= 1'b0;
            r_total     <= '0;
            r_rdpos     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_skip_mode <= i_cfg_wr_data;
            end
            r_total     <= n_total;
            r_rdpos     <= n_rdpos;
            r_out_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_result_valid = r_out_valid;
    assign o_result       = r_result;

    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_total <= TOT_W'(TABLE_DEPTH)) && (r_rdpos <= r_total))
        else $error("table count or read position out of range");

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_result_valid)
        else $error("accepted item gave no result");

    a_no_stray: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> !o_result_valid)
        else $error("result without an accepted item");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_result.status == ptt_pkg::ST_INSERTED))
            |-> (r_total == $past(r_total) + TOT_W'(1)))
        else $error("insert did not grow the table");

    a_merge_hits_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_eq))
        else $error("key matched more than one entry");

endmodule
